### hw/rtl/vtpd_pkg.sv
package vtpd_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int NUM_REGS       = 8;
    localparam int REG_WIDTH      = 64;
    localparam int SLOT_WIDTH     = 32;
    localparam int FIELD_WIDTH    = 32;
    localparam int INDEX_WIDTH    = 4;

endpackage

### hw/rtl/vertex_transform_perspective_divide.sv
// Homogeneous 4x4 vertex transform with perspective divide, signed fixed point.
// Input channel: in_valid / in_stall carry one vertex (in_x, in_y, in_z, in_w)
// per transfer. Output channel: out_valid / out_stall carry one result
// (out_x, out_y, out_z, out_w, divided, overflow) per input vertex, in order.
// The matrix sits in eight 64-bit registers written through cfg_we, cfg_index
// and cfg_data; indexes above seven are ignored. Write only while the pipe is
// empty.
// Throughput: one vertex per cycle while out_stall is low. Pipe stages, in
// order: one multiply stage, a row-sum stage, a saturate stage, a divider
// setup stage, one restoring quotient bit per stage for DATA_WIDTH stages,
// and the output register.
// Reset clears all valid bits and loads the identity matrix.
// When the receiver stalls, the output holds; each stage keeps taking data
// while a stage ahead of it is empty, so bubbles fill before in_stall rises.
module vertex_transform_perspective_divide #(
    parameter int FRAC_BITS  = vtpd_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = vtpd_pkg::DATA_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [vtpd_pkg::INDEX_WIDTH-1:0]      cfg_index,
    input  logic [vtpd_pkg::REG_WIDTH-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [vtpd_pkg::FIELD_WIDTH-1:0] in_x,
    input  logic signed [vtpd_pkg::FIELD_WIDTH-1:0] in_y,
    input  logic signed [vtpd_pkg::FIELD_WIDTH-1:0] in_z,
    input  logic signed [vtpd_pkg::FIELD_WIDTH-1:0] in_w,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [vtpd_pkg::FIELD_WIDTH-1:0] out_x,
    output logic signed [vtpd_pkg::FIELD_WIDTH-1:0] out_y,
    output logic signed [vtpd_pkg::FIELD_WIDTH-1:0] out_z,
    output logic signed [vtpd_pkg::FIELD_WIDTH-1:0] out_w,
    output logic                                  divided,
    output logic                                  overflow
);

    localparam int DW   = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int FW   = vtpd_pkg::FIELD_WIDTH;
    localparam int RGW  = vtpd_pkg::REG_WIDTH;
    localparam int PW   = 2 * DW;
    localparam int SW   = PW + 2;
    localparam int RW   = 2 * DW + F;
    localparam int NSTG = DW + 5;
    localparam bit ONE_FITS = (F < DW - 1);

    localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [SW-1:0] SMAX_W = SW'(SMAX);
    localparam logic signed [SW-1:0] SMIN_W = SW'(SMIN);
    localparam logic [RGW-1:0] ONE64 = RGW'(1) << F;
    localparam logic signed [PW-1:0] ONE_PW = PW'(1) << F;
    localparam logic signed [DW-1:0] ONE_DW = ONE_FITS ? DW'(ONE64) : SMAX;

    typedef struct packed {
        logic [2:0][RW-1:0]        rem;
        logic [2:0][DW-1:0]        q;
        logic [2:0]                neg;
        logic [2:0]                big;
        logic [RW-1:0]             dmag;
        logic [3:0][DW-1:0]        p;
        logic                      ovf;
        logic                      div;
    } dv_t;

    logic [RGW-1:0]           mat_reg [vtpd_pkg::NUM_REGS];
    logic signed [DW-1:0]     ent [4][4];
    logic signed [DW-1:0]     vin [4];
    logic signed [PW-1:0]     prod_reg [4][4];
    logic signed [SW-1:0]     sum_reg [4];
    logic signed [DW-1:0]     p_reg [4];
    logic                     pov_reg;
    dv_t                      dv_reg [DW+1];
    dv_t                      dv_next;
    logic [NSTG:1]            v_reg;
    logic [NSTG:1]            v_prev;
    logic [NSTG+1:1]          ld;
    logic signed [DW-1:0]     res_next [4];
    logic                     ovf_next;
    logic signed [DW-1:0]     res_reg [4];
    logic                     ovf_reg;
    logic                     div_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0] <= ONE64;
            mat_reg[1] <= '0;
            mat_reg[2] <= ONE64 << vtpd_pkg::SLOT_WIDTH;
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= ONE64;
            mat_reg[6] <= '0;
            mat_reg[7] <= ONE64 << vtpd_pkg::SLOT_WIDTH;
        end
        else if (cfg_we && cfg_index < vtpd_pkg::INDEX_WIDTH'(vtpd_pkg::NUM_REGS))
        begin
            mat_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    for (genvar c = 0; c < 4; c++)
    begin : g_col
        for (genvar r = 0; r < 4; r++)
        begin : g_row
            assign ent[c][r] =
                $signed(mat_reg[2*c + r/2][vtpd_pkg::SLOT_WIDTH*(r%2) +: DW]);
        end
    end

    assign vin[0] = $signed(in_x[DW-1:0]);
    assign vin[1] = $signed(in_y[DW-1:0]);
    assign vin[2] = $signed(in_z[DW-1:0]);
    assign vin[3] = $signed(in_w[DW-1:0]);

    // handshake: a stage loads when it is empty or the stage ahead loads
    always_comb
    begin
        ld[NSTG+1] = !out_stall;
        for (int k = NSTG; k >= 1; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign in_stall = !ld[1];
    assign v_prev   = {v_reg[NSTG-1:1], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 1; k <= NSTG; k++)
            begin
                if (ld[k])
                begin
                    v_reg[k] <= v_prev[k];
                end
            end
        end
    end

    // multiply
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    prod_reg[r][c] <= PW'(ent[c][r]) * PW'(vin[c]);
                end
            end
        end
    end

    // row sums
    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            for (int r = 0; r < 4; r++)
            begin
                sum_reg[r] <= SW'(prod_reg[r][0]) + SW'(prod_reg[r][1])
                            + SW'(prod_reg[r][2]) + SW'(prod_reg[r][3]);
            end
        end
    end

    // floor shift and saturate
    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            logic signed [SW-1:0] sh;
            logic                 ov;
            ov = 1'b0;
            for (int r = 0; r < 4; r++)
            begin
                sh = sum_reg[r] >>> F;
                if (sh > SMAX_W)
                begin
                    p_reg[r] <= SMAX;
                    ov = 1'b1;
                end
                else if (sh < SMIN_W)
                begin
                    p_reg[r] <= SMIN;
                    ov = 1'b1;
                end
                else
                begin
                    p_reg[r] <= sh[DW-1:0];
                end
            end
            pov_reg <= ov;
        end
    end

    // divider setup
    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            logic signed [DW:0] pe;
            logic [DW:0]        mag;
            logic [RW-1:0]      dm;
            logic [RW-1:0]      nm;
            pe = {p_reg[3][DW-1], p_reg[3]};
            mag = (pe < 0) ? (DW+1)'(-pe) : (DW+1)'(pe);
            dm = RW'(mag);
            dv_reg[0].dmag <= dm;
            for (int r = 0; r < 3; r++)
            begin
                pe = {p_reg[r][DW-1], p_reg[r]};
                mag = (pe < 0) ? (DW+1)'(-pe) : (DW+1)'(pe);
                nm = RW'(mag) << F;
                dv_reg[0].rem[r] <= nm;
                dv_reg[0].q[r]   <= '0;
                dv_reg[0].neg[r] <= p_reg[r][DW-1] ^ p_reg[3][DW-1];
                dv_reg[0].big[r] <= (nm >= (dm << DW));
            end
            for (int r = 0; r < 4; r++)
            begin
                dv_reg[0].p[r] <= p_reg[r];
            end
            dv_reg[0].ovf <= pov_reg;
            dv_reg[0].div <= (p_reg[3] != '0) && (PW'(p_reg[3]) != ONE_PW);
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 0; j < DW; j++)
    begin : g_div
        dv_t step;
        always_comb
        begin
            logic [RW-1:0] sh;
            step = dv_reg[j];
            sh = dv_reg[j].dmag << (DW - 1 - j);
            for (int r = 0; r < 3; r++)
            begin
                if (dv_reg[j].rem[r] >= sh)
                begin
                    step.rem[r]           = dv_reg[j].rem[r] - sh;
                    step.q[r][DW - 1 - j] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[5 + j])
            begin
                dv_reg[j+1] <= step;
            end
        end
    end

    // sign, saturate and select
    always_comb
    begin
        dv_next  = dv_reg[DW];
        ovf_next = dv_next.ovf;
        for (int r = 0; r < 4; r++)
        begin
            res_next[r] = dv_next.p[r];
        end
        if (dv_next.div)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (dv_next.big[r])
                begin
                    ovf_next    = 1'b1;
                    res_next[r] = dv_next.neg[r] ? SMIN : SMAX;
                end
                else if (dv_next.neg[r])
                begin
                    if (dv_next.q[r][DW-1] && |dv_next.q[r][DW-2:0])
                    begin
                        ovf_next    = 1'b1;
                        res_next[r] = SMIN;
                    end
                    else
                    begin
                        res_next[r] = $signed(DW'(-dv_next.q[r]));
                    end
                end
                else if (dv_next.q[r][DW-1])
                begin
                    ovf_next    = 1'b1;
                    res_next[r] = SMAX;
                end
                else
                begin
                    res_next[r] = $signed(dv_next.q[r]);
                end
            end
            res_next[3] = ONE_DW;
            if (!ONE_FITS)
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[NSTG])
        begin
            for (int r = 0; r < 4; r++)
            begin
                res_reg[r] <= res_next[r];
            end
            ovf_reg <= ovf_next;
            div_reg <= dv_next.div;
        end
    end

    assign out_valid = v_reg[NSTG];
    assign out_x     = FW'(res_reg[0]);
    assign out_y     = FW'(res_reg[1]);
    assign out_z     = FW'(res_reg[2]);
    assign out_w     = FW'(res_reg[3]);
    assign divided   = div_reg;
    assign overflow  = ovf_reg;

endmodule

### tb/vtpd_checker.sv
module vtpd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] in_x,
    input  logic [31:0] in_y,
    input  logic [31:0] in_z,
    input  logic [31:0] in_w,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] out_x,
    input  logic [31:0] out_y,
    input  logic [31:0] out_z,
    input  logic [31:0] out_w,
    input  logic        divided,
    input  logic        overflow,
    output int          errors,
    output int          pending,
    output int          n_div,
    output int          n_ovf
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = vtpd_pkg::FRAC_BITS_DEF;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam longint ONE = 64'sd1 << FB;

    typedef struct packed {
        logic [31:0] x, y, z, w;
        logic        dv, ov;
    } vertex_out_t;

    logic [63:0] matrix [vtpd_pkg::NUM_REGS];
    vertex_out_t expected_q [$];

    function automatic longint clamp(longint v, ref bit ov);
        if (v > SMAX) begin ov = 1; return SMAX; end
        if (v < SMIN) begin ov = 1; return SMIN; end
        return v;
    endfunction

    function automatic vertex_out_t transform(logic [31:0] v0, logic [31:0] v1,
                                              logic [31:0] v2, logic [31:0] v3);
        longint v [4];
        longint p [4];
        longint o [4];
        logic signed [127:0] acc;
        logic [63:0] reg_v;
        longint e;
        bit ov;
        vertex_out_t r;
        ov = 0;
        v[0] = longint'($signed(v0)); v[1] = longint'($signed(v1));
        v[2] = longint'($signed(v2)); v[3] = longint'($signed(v3));
        for (int row = 0; row < 4; row++) begin
            acc = 0;
            for (int c = 0; c < 4; c++) begin
                reg_v = matrix[c * 2 + row / 2];
                e = (row % 2) ? longint'($signed(reg_v[63:32]))
                              : longint'($signed(reg_v[31:0]));
                acc += 128'(e * v[c]);
            end
            acc = acc >>> FB;
            if (acc > SMAX) begin ov = 1; p[row] = SMAX; end
            else if (acc < SMIN) begin ov = 1; p[row] = SMIN; end
            else p[row] = longint'(acc);
        end
        r.dv = (p[3] != 0 && p[3] != ONE);
        for (int row = 0; row < 4; row++)
            o[row] = r.dv ? clamp((p[row] * ONE) / p[3], ov) : p[row];
        r.x = o[0][31:0]; r.y = o[1][31:0]; r.z = o[2][31:0]; r.w = o[3][31:0];
        r.ov = ov;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n) begin
        vertex_out_t e;
        if (!rst_n) begin
            matrix[0] = 64'h1_0000;       matrix[1] = 0;
            matrix[2] = 64'h1_0000 << 32; matrix[3] = 0;
            matrix[4] = 0;                matrix[5] = 64'h1_0000;
            matrix[6] = 0;                matrix[7] = 64'h1_0000 << 32;
            expected_q.delete();
            errors = 0; n_div = 0; n_ovf = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("unexpected result at %0t", $time);
                    errors++;
                end
                else begin
                    e = expected_q.pop_front();
                    if (out_x !== e.x) report("x", out_x, e.x);
                    if (out_y !== e.y) report("y", out_y, e.y);
                    if (out_z !== e.z) report("z", out_z, e.z);
                    if (out_w !== e.w) report("w", out_w, e.w);
                    if (divided !== e.dv) report("divided", divided, e.dv);
                    if (overflow !== e.ov) report("overflow", overflow, e.ov);
                    n_div += e.dv; n_ovf += e.ov;
                end
            end
            if (in_valid && !in_stall)
                expected_q.push_back(transform(in_x, in_y, in_z, in_w));
            if (cfg_we && cfg_index < vtpd_pkg::NUM_REGS)
                matrix[cfg_index[2:0]] = cfg_data;
        end
    end
endmodule

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [3:0] cfg_index = 0;
    logic [63:0] cfg_data = 0;
    logic in_valid = 0;
    logic in_stall;
    logic signed [31:0] in_x = 0, in_y = 0, in_z = 0, in_w = 0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [31:0] out_x, out_y, out_z, out_w;
    logic divided, overflow;
    logic sink_took = 0;
    int sink_wait = 0;
    int errors, pending, n_div, n_ovf, n_items, cycles;

    always #5 clk = ~clk;

    vertex_transform_perspective_divide u_dut (.*);

    vtpd_checker u_chk (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        sink_took <= out_valid && !out_stall;
    end

    // draw a fresh wait after every output transfer, then hold out_stall high until the wait counts down to zero
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_took)
            begin
                sink_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            if (sink_wait > 0)
            begin
                out_stall <= 1;
                sink_wait--;
            end
            else
            begin
                out_stall <= 0;
            end
        end
    end

    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0001_0000;
            3: return 0;
            4: return 32'(int'($urandom_range(0, 20)) - 10) << 16;
            5: return 32'($signed(16'($urandom))) ;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] entry_val(int mode);
        if (mode == 0) return 32'(int'($urandom_range(0, 8)) - 4) << 15;
        return pick_val();
    endfunction

    task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] w);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        cfg_we <= 0;
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_x <= x; in_y <= y; in_z <= z; in_w <= w;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        n_items++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (45) @(negedge clk);
    endtask

    task automatic write_reg(int idx, logic [63:0] val);
        cfg_we <= 1; cfg_index <= 4'(idx); cfg_data <= val;
        @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] e [0:7];
        int mode;
        repeat (9) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        send_vertex(32'h8000_0000, 32'h7fff_ffff, 0, 32'h0001_0000);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0);
        send_vertex(32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000);
        send_vertex(32'h0003_0000, 32'hfffe_0000, 32'h0001_0000, 32'hffff_8000);
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001);
        send_vertex(32'h8000_0000, 0, 0, 32'hffff_ffff);
        drain();
        write_reg(7, {32'h7fff_ffff, 32'h0}); write_reg(6, {32'h8000_0000, 32'h7fff_ffff});
        write_reg(9, 64'hdead_beef);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vertex(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_vertex(0, 0, 0, 0);
        drain();
        for (int phase = 0; phase < 11; phase++)
        begin
            mode = phase % 3;
            for (int i = 0; i < 8; i++) e[i] = entry_val(mode);
            if (phase == 10) for (int i = 0; i < 8; i++) e[i] = 32'h8000_0000;
            for (int i = 0; i < 8; i++) write_reg(i, {e[i], entry_val(mode)});
            if (phase == 5) write_reg(3, {32'h0, 32'h0});
            for (int i = 0; i < 100; i++)
                send_vertex(pick_val(), pick_val(), pick_val(),
                            ($urandom_range(0, 4) == 0) ? 32'h0001_0000 : pick_val());
            drain();
        end
        $display("tb: %0d vertices over 13 matrix settings, %0d divided, %0d saturated",
                 n_items, n_div, n_ovf);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
